// ===== hdl/hpsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// hpsdm_pkg
// Shared types, codes and constants of the Hall pulse speed/direction meter.
// ----------------------------------------------------------------------------
package hpsdm_pkg;

  localparam int unsigned TimeBits  = 16;  // capture timestamp width
  localparam int unsigned ModBits   = 17;  // counter modulus / pulse width
  localparam int unsigned PerBits   = 18;  // pulse period
  localparam int unsigned CntBits   = 16;  // edge counters
  localparam int unsigned NumBits   = 32;  // speed numerator
  localparam int unsigned ScaleBits = 16;  // period scale
  localparam int unsigned DivBits   = PerBits + ScaleBits;  // divisor width
  localparam int unsigned SpdBits   = 16;  // speed result
  localparam int unsigned StepBits  = $clog2(NumBits);

  localparam logic [SpdBits-1:0] SpeedFloor = SpdBits'(10);
  localparam logic [1:0]         StallHold  = 2'd2;
  localparam logic [1:0]         FillFull   = 2'd3;

  localparam logic [ModBits-1:0] ResetModulus   = ModBits'(65536);
  localparam logic [NumBits-1:0] ResetNumerator = NumBits'(60000000);
  localparam logic [ScaleBits-1:0] ResetScale   = ScaleBits'(1);
  localparam logic               ResetInvert    = 1'b1;

  // Opcodes of an input transaction
  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpEdgeA   = 3'd1;
  localparam logic [2:0] OpEdgeB   = 3'd2;
  localparam logic [2:0] OpClrBoth = 3'd3;
  localparam logic [2:0] OpClrA    = 3'd4;
  localparam logic [2:0] OpClrB    = 3'd5;

  // Direction codes
  localparam logic [1:0] DirHalt = 2'd0;
  localparam logic [1:0] DirPos  = 2'd1;
  localparam logic [1:0] DirNeg  = 2'd2;

  // Register indexes on the APB port
  localparam logic [1:0] RegModulus   = 2'd0;
  localparam logic [1:0] RegNumerator = 2'd1;
  localparam logic [1:0] RegScale     = 2'd2;
  localparam logic [1:0] RegInvert    = 2'd3;

  typedef struct packed {
    logic [2:0]          op;
    logic [TimeBits-1:0] ctime;
    logic                level_a;
    logic                level_b;
  } evt_item_t;

  typedef struct packed {
    logic [ModBits-1:0] modulus;
    logic               invert;
  } evt_cfg_t;

  typedef struct packed {
    logic [ModBits-1:0] width;
    logic [PerBits-1:0] period;
    logic [1:0]         dir;
    logic [CntBits-1:0] count_a;
    logic [CntBits-1:0] count_b;
    logic [CntBits-1:0] count_sum;
    logic               stalled;
  } evt_res_t;

endpackage

// ===== hdl/hpsdm_event.sv =====
// ----------------------------------------------------------------------------
// hpsdm_event
// Channel state: timestamps, overflow count, width, period, direction and
// edge counts. Applies one event per strobe and registers a status snapshot.
// ----------------------------------------------------------------------------
module hpsdm_event import hpsdm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      apply_i,
  input  evt_item_t item_i,
  input  evt_cfg_t  cfg_i,
  output evt_res_t  res_o
);

  logic [TimeBits-1:0] t_old_q, t_old_d, t_mid_q, t_mid_d, t_new_q, t_new_d;
  logic [1:0]          fill_q, fill_d;
  logic [1:0]          ovf_q, ovf_d;
  logic [ModBits-1:0]  width_q, width_d;
  logic [PerBits-1:0]  period_q, period_d;
  logic [1:0]          dir_q, dir_d;
  logic [CntBits-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  evt_res_t            res_q, res_d;

  logic [ModBits-1:0] half_mod;
  logic [ModBits-1:0] d1, d2;

  function automatic logic [ModBits-1:0] wrap_diff(input logic [ModBits-1:0] modulus,
                                                    input logic [TimeBits-1:0] older,
                                                    input logic [TimeBits-1:0] newer);
    logic [ModBits-1:0] o, n;
    o = ModBits'(older);
    n = ModBits'(newer);
    if (newer < older) begin
      return modulus - o + n;
    end
    return n - o;
  endfunction

  assign half_mod = cfg_i.modulus >> 1;

  always_comb begin
    t_old_d  = t_old_q;
    t_mid_d  = t_mid_q;
    t_new_d  = t_new_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    width_d  = width_q;
    period_d = period_q;
    dir_d    = dir_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    d1       = half_mod;
    d2       = half_mod;
    res_d    = res_q;

    if (apply_i) begin
      unique case (item_i.op)
        OpTick: begin
          if (ovf_q < StallHold) begin
            ovf_d = ovf_q + 2'd1;
          end
          if (ovf_d == StallHold) begin
            width_d  = half_mod;
            period_d = PerBits'(cfg_i.modulus);
          end
        end
        OpEdgeA: begin
          t_old_d = t_mid_q;
          t_mid_d = t_new_q;
          t_new_d = item_i.ctime;
          if (fill_q != FillFull) begin
            fill_d = fill_q + 2'd1;
          end
          if (fill_d == FillFull) begin
            // stalled channel falls back to the default width and period
            if (ovf_q != StallHold) begin
              d1 = wrap_diff(cfg_i.modulus, t_old_d, t_mid_d);
              d2 = wrap_diff(cfg_i.modulus, t_mid_d, t_new_d);
            end
            width_d  = item_i.level_a ? d1 : d2;
            period_d = PerBits'(d1) + PerBits'(d2);
            cnt_a_d  = cnt_a_q + CntBits'(1);
            ovf_d    = 2'd0;
          end
        end
        OpEdgeB: begin
          cnt_b_d = cnt_b_q + CntBits'(1);
          dir_d   = ((item_i.level_a == item_i.level_b) == cfg_i.invert) ? DirNeg : DirPos;
        end
        default: begin
        end
      endcase

      res_d.width     = width_d;
      res_d.period    = period_d;
      res_d.dir       = dir_d;
      res_d.count_a   = cnt_a_d;
      res_d.count_b   = cnt_b_d;
      res_d.count_sum = cnt_a_d + cnt_b_d;
      res_d.stalled   = (ovf_d == StallHold);

      // read-clear ops act after the snapshot
      if (item_i.op == OpClrBoth || item_i.op == OpClrA) begin
        cnt_a_d = '0;
      end
      if (item_i.op == OpClrBoth || item_i.op == OpClrB) begin
        cnt_b_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_old_q  <= '0;
      t_mid_q  <= '0;
      t_new_q  <= '0;
      fill_q   <= '0;
      ovf_q    <= '0;
      width_q  <= ResetModulus >> 1;
      period_q <= PerBits'(ResetModulus);
      dir_q    <= DirHalt;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
    end else begin
      t_old_q  <= t_old_d;
      t_mid_q  <= t_mid_d;
      t_new_q  <= t_new_d;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      width_q  <= width_d;
      period_q <= period_d;
      dir_q    <= dir_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q != 2'd3) else $error("overflow count beyond hold");

  a_edge_clears_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_i && item_i.op == OpEdgeA && fill_q == FillFull |=> ovf_q == 2'd0)
    else $error("A edge with full history left overflow count set");

endmodule

// ===== hdl/hpsdm_div.sv =====
// ----------------------------------------------------------------------------
// hpsdm_div
// Speed unit: one registered multiply for the divisor, then a restoring
// divider, one quotient bit per cycle. Keeps the low quotient bits only.
// ----------------------------------------------------------------------------
module hpsdm_div import hpsdm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumBits-1:0]   numerator_i,
  input  logic [PerBits-1:0]   period_i,
  input  logic [ScaleBits-1:0] scale_i,
  output logic                 done_o,
  output logic [SpdBits-1:0]   speed_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [NumBits-1:0]   num_q, num_d;
  logic [DivBits-1:0]   prod_q, prod_d;
  logic [DivBits-1:0]   rem_q, rem_d;
  logic [SpdBits-1:0]   quo_q, quo_d;
  logic [DivBits:0]     trial;
  logic                 fits;

  // shared compare/subtract step
  assign trial = {rem_q, num_q[NumBits-1]} - {1'b0, prod_q};
  assign fits  = ({rem_q, num_q[NumBits-1]} >= {1'b0, prod_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      num_d  = numerator_i;
      prod_d = DivBits'(period_i) * DivBits'(scale_i);
      rem_d  = '0;
      quo_d  = '0;
    end else if (run_q) begin
      rem_d  = fits ? trial[DivBits-1:0] : {rem_q[DivBits-2:0], num_q[NumBits-1]};
      num_d  = num_q << 1;
      quo_d  = {quo_q[SpdBits-2:0], fits};
      step_d = step_q + StepBits'(1);
      if (step_q == StepBits'(NumBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o  = done_q;
  assign speed_o = (prod_q == '0 || quo_q < SpeedFloor) ? '0 : quo_q;

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q && step_q == '0) else $error("divider did not start");

endmodule

// ===== hdl/hall_pulse_speed_direction_meter.sv =====
// ----------------------------------------------------------------------------
// hall_pulse_speed_direction_meter
// Single Hall channel meter: pulse width, period, direction, edge counts and
// speed = numerator / (period * scale), one status transaction per event.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: opcode; tdata: time, A, B
//  m_axis    out  tvalid/tready          tdata: status and speed
//  apb       in   psel/penable/pready    4 x 32-bit registers at 4*i
//
//  An event is applied at the accept edge; then the period is multiplied by
//  scale, the restoring divider runs (one quotient bit per cycle), the
//  sequencer sees the divider done, and the output register is loaded. The
//  divider sets the rate unless the output register holds the load.
//  s_axis_tready is high only while idle; a result waiting in the output
//  register does not block the next event, only the load of the following.
//  Reset (rst_ni low, asynchronous) restores config, channel and FSM state only.
// ----------------------------------------------------------------------------
module hall_pulse_speed_direction_meter import hpsdm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input events
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [15:0] capture_time, [16] level_a, [17] level_b
  input  logic [2:0]   s_axis_tuser,   // [2:0] opcode
  // status results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [16:0] pulse_width_out, [34:17] pulse_period_out,
                                       // [36:35] direction_out, [52:37] count_a_out,
                                       // [68:53] count_b_out, [84:69] count_sum_out,
                                       // [100:85] speed_out, [101] stalled
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [ModBits-1:0]   modulus_q;
  logic [NumBits-1:0]   numerator_q;
  logic [ScaleBits-1:0] scale_q;
  logic                 invert_q;
  logic                 cfg_wr;

  evt_item_t item;
  evt_cfg_t  evt_cfg;
  evt_res_t  res;
  logic      accept;
  logic      div_start;
  logic      div_done;
  logic [SpdBits-1:0] speed;

  logic          out_valid_q, out_valid_d;
  logic [103:0]  out_data_q, out_data_d;
  logic          out_load;

  // --- APB ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= ResetModulus;
      numerator_q <= ResetNumerator;
      scale_q     <= ResetScale;
      invert_q    <= ResetInvert;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegModulus:   modulus_q   <= pwdata[ModBits-1:0];
        RegNumerator: numerator_q <= pwdata;
        RegScale:     scale_q     <= pwdata[ScaleBits-1:0];
        RegInvert:    invert_q    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegModulus:   prdata = 32'(modulus_q);
      RegNumerator: prdata = numerator_q;
      RegScale:     prdata = 32'(scale_q);
      RegInvert:    prdata = 32'(invert_q);
      default:      prdata = '0;
    endcase
  end

  // --- event unit ---
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item.op       = s_axis_tuser;
  assign item.ctime    = s_axis_tdata[TimeBits-1:0];
  assign item.level_a  = s_axis_tdata[16];
  assign item.level_b  = s_axis_tdata[17];
  assign evt_cfg.modulus = modulus_q;
  assign evt_cfg.invert  = invert_q;

  hpsdm_event u_event (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .apply_i (accept),
    .item_i  (item),
    .cfg_i   (evt_cfg),
    .res_o   (res)
  );

  // --- speed unit ---
  assign div_start = (state_q == ST_START);

  hpsdm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .numerator_i (numerator_q),
    .period_i    (res.period),
    .scale_i     (scale_q),
    .done_o      (div_done),
    .speed_o     (speed)
  );

  // --- sequencer ---
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept)   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --- output register ---
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {2'b00, res.stalled, speed, res.count_sum, res.count_b,
                     res.count_a, res.dir, res.period, res.width};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_START) else $error("accepted event did not start speed unit");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid) else $error("loaded result not presented");

endmodule
